// ===== rtl/ket_pkg.sv =====
package ket_pkg;

    localparam logic [1:0] CMD_EVENT = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLR_HIST = 2'd2;
    localparam logic [1:0] CMD_CLR_ALL = 2'd3;

    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam int KEY_COUNT = 256;

    // history depth: fill and pointer widths are sized for it
    localparam int HISTORY_DEPTH = 128;

    localparam logic [2:0] REG_EVENTS_EN = 3'd0;
    localparam logic [2:0] REG_BKSP_EDIT = 3'd1;
    localparam logic [2:0] REG_RANGE_CNT = 3'd2;
    localparam logic [2:0] REG_RANGE_A = 3'd3;
    localparam logic [2:0] REG_RANGE_B = 3'd4;
    localparam logic [2:0] REG_PATTERN = 3'd5;
    localparam logic [2:0] REG_MATCH_LEN = 3'd6;

    // history operation decided by the front end
    localparam logic [1:0] HOP_NONE = 2'd0;
    localparam logic [1:0] HOP_PUSH = 2'd1;
    localparam logic [1:0] HOP_POP = 2'd2;
    localparam logic [1:0] HOP_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0] hop;
        logic [7:0] key;
        logic       reported;
        logic       down;
        logic       pressed;
        logic       released;
    } t_job;

endpackage

// ===== rtl/ket_front.sv =====
// Key flag tracking and command classification.
// Flags live in a 256 x 3 memory; clear all and reset sweep it to zero.
module ket_front #(
    parameter int RANGE_SLOTS = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [1:0]      i_command,
    input  logic [7:0]      i_key,
    input  logic            i_pressed,
    input  logic            i_events_enabled,
    input  logic            i_backspace_editing,
    input  logic [1:0]      i_range_count,
    input  logic [15:0]     i_range_a,
    input  logic [15:0]     i_range_b,
    output logic            o_clearing,
    output logic            o_job_valid,
    output ket_pkg::t_job   o_job
);

    localparam int MAX_RANGES = (RANGE_SLOTS < 2) ? RANGE_SLOTS : 2;

    localparam logic [1:0] FS_CLEAR = 2'd0;
    localparam logic [1:0] FS_IDLE = 2'd1;
    localparam logic [1:0] FS_UPDATE = 2'd2;

    // per key: {down, pressed, released}
    logic [2:0]    r_flags [ket_pkg::KEY_COUNT];
    logic [2:0]    r_rd;
    logic [1:0]    r_state;
    logic [7:0]    r_clr_addr;
    logic [1:0]    r_cmd;
    logic [7:0]    r_key;
    logic          r_prs;
    logic          r_job_valid;
    ket_pkg::t_job r_job, n_job;

    logic       cur_d, cur_p, cur_r, accepted;
    logic [1:0] n_used;
    logic       flag_we;
    logic [7:0] flag_wa;
    logic [2:0] flag_wd;

    always_comb begin
        n_used = (i_range_count > 2'(MAX_RANGES)) ? 2'(MAX_RANGES) : i_range_count;
        accepted = (n_used == 2'd0)
            || (n_used >= 2'd1 && r_key >= i_range_a[7:0] && r_key <= i_range_a[15:8])
            || (n_used >= 2'd2 && r_key >= i_range_b[7:0] && r_key <= i_range_b[15:8]);
    end

    always_comb begin
        cur_d = r_rd[2];
        cur_p = r_rd[1];
        cur_r = r_rd[0];
        n_job = '0;
        n_job.key = r_key;
        n_job.hop = ket_pkg::HOP_NONE;
        flag_we = 1'b0;
        flag_wa = r_key;
        unique case (r_cmd)
            ket_pkg::CMD_EVENT: begin
                if (r_prs) begin
                    if (!cur_d) begin
                        cur_d = 1'b1;
                        cur_p = 1'b1;
                        cur_r = 1'b0;
                        if (i_events_enabled) begin
                            n_job.reported = 1'b1;
                            if (i_backspace_editing && r_key == ket_pkg::KEY_BACKSPACE) begin
                                n_job.hop = ket_pkg::HOP_POP;
                            end else if (accepted) begin
                                n_job.hop = ket_pkg::HOP_PUSH;
                            end
                        end
                    end else begin
                        cur_p = 1'b0;
                    end
                end else begin
                    if (cur_d) begin
                        cur_d = 1'b0;
                        cur_p = 1'b0;
                        cur_r = 1'b1;
                        n_job.reported = i_events_enabled;
                    end else begin
                        cur_r = 1'b0;
                    end
                end
                flag_we = (r_state == FS_UPDATE);
            end
            ket_pkg::CMD_QUERY: begin
            end
            ket_pkg::CMD_CLR_HIST: begin
                n_job.hop = ket_pkg::HOP_CLEAR;
            end
            ket_pkg::CMD_CLR_ALL: begin
                // flags are wiped by the sweep that follows
                cur_d = 1'b0;
                cur_p = 1'b0;
                cur_r = 1'b0;
                n_job.hop = ket_pkg::HOP_CLEAR;
            end
            default: begin
            end
        endcase
        flag_wd = {cur_d, cur_p, cur_r};
        if (r_state == FS_CLEAR) begin
            flag_we = 1'b1;
            flag_wa = r_clr_addr;
            flag_wd = '0;
        end
        n_job.down = cur_d;
        n_job.pressed = cur_p;
        n_job.released = cur_r;
    end

    // read at the accept edge, write on update or sweep
    always_ff @(posedge i_clk) begin
        r_rd <= r_flags[i_key];
        if (flag_we) begin
            r_flags[flag_wa] <= flag_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_CLEAR;
            r_clr_addr <= '0;
            r_job_valid <= 1'b0;
            r_cmd <= ket_pkg::CMD_QUERY;
            r_key <= '0;
            r_prs <= 1'b0;
        end else begin
            r_job_valid <= 1'b0;
            unique case (r_state)
                FS_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 8'd1;
                    if (r_clr_addr == 8'hFF) begin
                        r_state <= FS_IDLE;
                    end
                end
                FS_IDLE: begin
                    if (i_go) begin
                        r_cmd <= i_command;
                        r_key <= i_key;
                        r_prs <= i_pressed;
                        r_state <= FS_UPDATE;
                    end
                end
                FS_UPDATE: begin
                    r_job_valid <= 1'b1;
                    r_state <= (r_cmd == ket_pkg::CMD_CLR_ALL) ? FS_CLEAR : FS_IDLE;
                end
                default: r_state <= FS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FS_UPDATE) begin
            r_job <= n_job;
        end
    end

    assign o_clearing = (r_state == FS_CLEAR);
    assign o_job_valid = r_job_valid;
    assign o_job = r_job;

endmodule

// ===== rtl/ket_back.sv =====
// History update and pattern match: one memory read per cycle.
module ket_back #(
    parameter int PATTERN_BYTES = 8,
    localparam int AW = $clog2(ket_pkg::HISTORY_DEPTH),
    localparam int CW = $clog2(ket_pkg::HISTORY_DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  ket_pkg::t_job   i_job,
    output logic            o_job_ready,
    input  logic [63:0]     i_pattern,
    input  logic [3:0]      i_match_length,
    output logic            o_valid,
    output logic            o_event_reported,
    output logic            o_key_down,
    output logic            o_key_pressed,
    output logic            o_key_released,
    output logic [7:0]      o_history_fill,
    output logic [7:0]      o_newest_key,
    output logic            o_pattern_match
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [7:0]    r_mem [ket_pkg::HISTORY_DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [1:0]    r_state;
    logic [3:0]    r_idx;
    logic [3:0]    r_len;
    logic          r_match;
    logic [7:0]    r_newest;
    ket_pkg::t_job r_job;
    logic          r_valid;

    logic [AW-1:0] rd_addr;
    logic [7:0]    want;
    logic [3:0]    len_sat;

    assign len_sat = (i_match_length > 4'(PATTERN_BYTES)) ? 4'(PATTERN_BYTES) : i_match_length;
    assign rd_addr = r_head - AW'(1) - AW'(r_idx);
    assign want = i_pattern[8*r_idx[2:0] +: 8];
    assign o_job_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (r_state == ST_IDLE && i_job_valid && i_job.hop == ket_pkg::HOP_PUSH) begin
            r_mem[r_head] <= i_job.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        r_match <= 1'b1;
                        r_newest <= 8'd0;
                        r_state <= ST_READ;
                        unique case (i_job.hop)
                            ket_pkg::HOP_PUSH: begin
                                r_head <= r_head + AW'(1);
                                if (r_count < CW'(ket_pkg::HISTORY_DEPTH)) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            ket_pkg::HOP_POP: begin
                                if (r_count != '0) begin
                                    r_head <= r_head - AW'(1);
                                    r_count <= r_count - CW'(1);
                                end
                            end
                            ket_pkg::HOP_CLEAR: begin
                                r_head <= '0;
                                r_count <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_len <= len_sat;
                    if (32'(len_sat) > 32'(r_count)) begin
                        r_match <= 1'b0;
                    end
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    // r_rdata holds entry r_idx back from newest
                    if (r_idx == 4'd0 && r_count != '0) begin
                        r_newest <= r_rdata;
                    end
                    if (r_idx < r_len && want != 8'd0 && want != r_rdata) begin
                        r_match <= 1'b0;
                    end
                    if (r_idx + 4'd1 >= r_len) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + 4'd1;
                        r_state <= ST_READ;
                    end
                end
                ST_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_event_reported = r_job.reported;
    assign o_key_down = r_job.down;
    assign o_key_pressed = r_job.pressed;
    assign o_key_released = r_job.released;
    assign o_history_fill = 8'(r_count);
    assign o_newest_key = r_newest;
    assign o_pattern_match = r_match;

endmodule

// ===== rtl/key_event_tracker_with_history_match_core.sv =====
// From start to o_valid: flag read and update, then one history read and compare per
// byte, for max(match_length, 1) bytes with match_length capped at 8.
// One word at a time: a new word is accepted only after the last result; clear all
// state adds a flag sweep with busy high.
// Reset (i_rst_n low, synchronous) clears registers and history pointers, then sweeps
// the key flags with busy high. The receiver cannot stall.
module key_event_tracker_with_history_match_core #(
    parameter int PATTERN_BYTES = 8,
    parameter int RANGE_SLOTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_key,
    input  logic        i_pressed,
    output logic        o_valid,
    output logic        o_event_reported,
    output logic        o_key_down,
    output logic        o_key_pressed,
    output logic        o_key_released,
    output logic [7:0]  o_history_fill,
    output logic [7:0]  o_newest_key,
    output logic        o_pattern_match,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Configuration registers, 8-byte stride (the pattern is 64 bits).
    logic        r_events_enabled;
    logic        r_backspace_editing;
    logic [1:0]  r_range_count;
    logic [15:0] r_range_a;
    logic [15:0] r_range_b;
    logic [63:0] r_pattern;
    logic [3:0]  r_match_length;

    logic [2:0] reg_idx;
    assign reg_idx = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_events_enabled <= 1'b0;
            r_backspace_editing <= 1'b0;
            r_range_count <= '0;
            r_range_a <= '0;
            r_range_b <= '0;
            r_pattern <= '0;
            r_match_length <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                ket_pkg::REG_EVENTS_EN: r_events_enabled <= pwdata[0];
                ket_pkg::REG_BKSP_EDIT: r_backspace_editing <= pwdata[0];
                ket_pkg::REG_RANGE_CNT: r_range_count <= pwdata[1:0];
                ket_pkg::REG_RANGE_A: r_range_a <= pwdata[15:0];
                ket_pkg::REG_RANGE_B: r_range_b <= pwdata[15:0];
                ket_pkg::REG_PATTERN: r_pattern <= pwdata;
                ket_pkg::REG_MATCH_LEN: r_match_length <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ket_pkg::REG_EVENTS_EN: prdata = {63'd0, r_events_enabled};
            ket_pkg::REG_BKSP_EDIT: prdata = {63'd0, r_backspace_editing};
            ket_pkg::REG_RANGE_CNT: prdata = {62'd0, r_range_count};
            ket_pkg::REG_RANGE_A: prdata = {48'd0, r_range_a};
            ket_pkg::REG_RANGE_B: prdata = {48'd0, r_range_b};
            ket_pkg::REG_PATTERN: prdata = r_pattern;
            ket_pkg::REG_MATCH_LEN: prdata = {60'd0, r_match_length};
            default: prdata = '0;
        endcase
    end

    // One word in flight: busy from accept until the result strobe,
    // and while the front sweeps its flag memory.
    logic r_busy;
    logic front_clearing;
    logic go;
    assign busy = r_busy || front_clearing;
    assign go = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (go) begin
            r_busy <= 1'b1;
        end else if (o_valid) begin
            r_busy <= 1'b0;
        end
    end

    // Front: key flags and classification; hands a job word to the back end.
    logic          job_valid;
    logic          job_ready;
    ket_pkg::t_job job;

    ket_front #(
        .RANGE_SLOTS(RANGE_SLOTS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_go               (go),
        .i_command          (i_command),
        .i_key              (i_key),
        .i_pressed          (i_pressed),
        .i_events_enabled   (r_events_enabled),
        .i_backspace_editing(r_backspace_editing),
        .i_range_count      (r_range_count),
        .i_range_a          (r_range_a),
        .i_range_b          (r_range_b),
        .o_clearing         (front_clearing),
        .o_job_valid        (job_valid),
        .o_job              (job)
    );

    // Back: history memory update, newest readout and pattern compare.
    ket_back #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid && job_ready),
        .i_job           (job),
        .o_job_ready     (job_ready),
        .i_pattern       (r_pattern),
        .i_match_length  (r_match_length),
        .o_valid         (o_valid),
        .o_event_reported(o_event_reported),
        .o_key_down      (o_key_down),
        .o_key_pressed   (o_key_pressed),
        .o_key_released  (o_key_released),
        .o_history_fill  (o_history_fill),
        .o_newest_key    (o_newest_key),
        .o_pattern_match (o_pattern_match)
    );

endmodule

// ===== verif/key_event_tracker_with_history_match_core_checker.sv =====
`timescale 1ns / 100ps

module key_event_tracker_with_history_match_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_key,
    input  logic        i_pressed,
    input  logic        o_valid,
    input  logic        o_event_reported,
    input  logic        o_key_down,
    input  logic        o_key_pressed,
    input  logic        o_key_released,
    input  logic [7:0]  o_history_fill,
    input  logic [7:0]  o_newest_key,
    input  logic        o_pattern_match,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic       reported;
        logic       down;
        logic       pressed;
        logic       released;
        logic [7:0] fill;
        logic [7:0] newest;
        logic       match;
    } t_status;

    logic        ev_en, bksp_en;
    logic [1:0]  rng_cnt;
    logic [15:0] rng_a, rng_b;
    logic [63:0] pat;
    logic [3:0]  pat_len;

    logic [255:0] down_q, press_q, rel_q;
    logic [7:0]   hist [128];
    int           head, count;

    // expected words in accept order
    t_status      exp_ring [64];
    int           exp_wr, exp_rd;

    assign o_pending = exp_wr - exp_rd;

    function automatic logic [7:0] hist_at(int age);
        return hist[(head + 127 - age) % 128];
    endfunction

    function automatic bit key_in_range(logic [15:0] b, logic [7:0] k);
        return k >= b[7:0] && k <= b[15:8];
    endfunction

    function automatic bit key_passes(logic [7:0] k);
        if (rng_cnt == 0) return 1;
        if (key_in_range(rng_a, k)) return 1;
        return rng_cnt >= 2 && key_in_range(rng_b, k);
    endfunction

    function automatic logic pattern_hit();
        int n;
        logic [7:0] want;
        n = (pat_len > 8) ? 8 : pat_len;
        if (n > count) return 0;
        for (int i = 0; i < n; i++) begin
            want = pat[8*i +: 8];
            if (want != 0 && want != hist_at(i)) return 0;
        end
        return 1;
    endfunction

    // update the key/history image for one word and queue the status
    task automatic track_word(logic [1:0] cmd, logic [7:0] k, logic prs);
        t_status s;
        s = '0;
        if (cmd == ket_pkg::CMD_EVENT) begin
            if (prs) begin
                if (!down_q[k]) begin
                    down_q[k] = 1; press_q[k] = 1; rel_q[k] = 0;
                    if (ev_en) begin
                        s.reported = 1;
                        if (bksp_en && k == ket_pkg::KEY_BACKSPACE) begin
                            if (count > 0) begin
                                head = (head + 127) % 128;
                                count--;
                            end
                        end else if (key_passes(k)) begin
                            hist[head] = k;
                            head = (head + 1) % 128;
                            if (count < 128) count++;
                        end
                    end
                end else press_q[k] = 0;
            end else begin
                if (down_q[k]) begin
                    down_q[k] = 0; press_q[k] = 0; rel_q[k] = 1;
                    s.reported = ev_en;
                end else rel_q[k] = 0;
            end
        end else if (cmd == ket_pkg::CMD_CLR_HIST) begin
            head = 0; count = 0;
        end else if (cmd == ket_pkg::CMD_CLR_ALL) begin
            down_q = '0; press_q = '0; rel_q = '0;
            head = 0; count = 0;
        end
        s.down = down_q[k];
        s.pressed = press_q[k];
        s.released = rel_q[k];
        s.fill = 8'(count);
        s.newest = (count != 0) ? hist_at(0) : 8'd0;
        s.match = pattern_hit();
        exp_ring[exp_wr % 64] = s;
        exp_wr++;
    endtask

    t_status got, exp_s;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ev_en <= 0; bksp_en <= 0; rng_cnt <= 0; rng_a <= 0; rng_b <= 0;
            pat <= 0; pat_len <= 0;
            down_q = '0; press_q = '0; rel_q = '0;
            head = 0; count = 0;
            o_fail_count <= 0;
            exp_wr = 0; exp_rd = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    ket_pkg::REG_EVENTS_EN: ev_en   <= pwdata[0];
                    ket_pkg::REG_BKSP_EDIT: bksp_en <= pwdata[0];
                    ket_pkg::REG_RANGE_CNT: rng_cnt <= pwdata[1:0];
                    ket_pkg::REG_RANGE_A:   rng_a   <= pwdata[15:0];
                    ket_pkg::REG_RANGE_B:   rng_b   <= pwdata[15:0];
                    ket_pkg::REG_PATTERN:   pat     <= pwdata;
                    ket_pkg::REG_MATCH_LEN: pat_len <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (start && !busy) track_word(i_command, i_key, i_pressed);
            if (o_valid) begin
                got = '{o_event_reported, o_key_down, o_key_pressed, o_key_released,
                        o_history_fill, o_newest_key, o_pattern_match};
                if (exp_wr == exp_rd) begin
                    if (o_fail_count < 10) $display("unexpected word: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_s = exp_ring[exp_rd % 64];
                    exp_rd++;
                    if (got !== exp_s) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp %p got %p", exp_s, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/key_event_tracker_with_history_match_core_tb.sv =====
`timescale 1ns / 100ps

module key_event_tracker_with_history_match_core_tb;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_command = ket_pkg::CMD_QUERY;
    logic [7:0]  i_key = 0;
    logic        i_pressed = 0;
    logic        o_valid, o_event_reported, o_key_down, o_key_pressed;
    logic        o_key_released, o_pattern_match;
    logic [7:0]  o_history_fill, o_newest_key;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [5:0]  paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          cycles = 0;

    always #5 i_clk = ~i_clk;

    key_event_tracker_with_history_match_core i_dut (.*);
    key_event_tracker_with_history_match_core_checker i_chk (.*, .o_fail_count(fail_count),
                                                            .o_pending(pending));

    // hard stop well beyond the slowest legal run (~1100 words)
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // APB write: setup then access; registers sit at 8*index
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // wait until every word has come back and the block is idle
    task automatic drain();
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    int burst_left = 0;

    // issue one word; with gaps set, random gaps between bursts
    task automatic send_word(logic [1:0] cmd, logic [7:0] k, logic prs, bit gaps);
        if (gaps) begin
            if (burst_left == 0) begin
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        @(negedge i_clk);
        start <= 1; i_command <= cmd; i_key <= k; i_pressed <= prs;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start <= 0;
    endtask

    // mostly a small key set so presses/repeats/releases pair up
    task automatic random_words(int n, bit gaps);
        int r;
        logic [7:0] k;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                (($urandom_range(0, 3) == 0) ? ket_pkg::KEY_BACKSPACE :
                 8'($urandom_range(8'h30, 8'h3F)));
            if (r < 85)      send_word(ket_pkg::CMD_EVENT, k, 1'($urandom), gaps);
            else if (r < 93) send_word(ket_pkg::CMD_QUERY, k, 1'($urandom), gaps);
            else if (r < 97) send_word(ket_pkg::CMD_CLR_HIST, k, 1'($urandom), gaps);
            else             send_word(ket_pkg::CMD_CLR_ALL, k, 1'($urandom), gaps);
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: reporting off, then on with every command
        send_word(ket_pkg::CMD_EVENT, 8'h41, 1, 0);
        send_word(ket_pkg::CMD_EVENT, 8'h41, 0, 0);
        drain();
        reg_write(ket_pkg::REG_EVENTS_EN, 1);
        reg_write(ket_pkg::REG_BKSP_EDIT, 1);
        reg_write(ket_pkg::REG_PATTERN, 64'h0000_0000_0000_42_00);
        reg_write(ket_pkg::REG_MATCH_LEN, 2);
        send_word(ket_pkg::CMD_EVENT, ket_pkg::KEY_BACKSPACE, 1, 0); // backspace, empty history
        send_word(ket_pkg::CMD_EVENT, 8'h00, 1, 0);
        send_word(ket_pkg::CMD_EVENT, 8'hFF, 1, 0);
        send_word(ket_pkg::CMD_EVENT, 8'h42, 1, 0);
        send_word(ket_pkg::CMD_EVENT, 8'h43, 1, 0);
        send_word(ket_pkg::CMD_EVENT, 8'h43, 1, 0);           // repeat press
        send_word(ket_pkg::CMD_EVENT, 8'h43, 1, 0);
        send_word(ket_pkg::CMD_EVENT, 8'h43, 0, 0);
        send_word(ket_pkg::CMD_EVENT, 8'h43, 0, 0);           // repeat release
        send_word(ket_pkg::CMD_EVENT, 8'h43, 0, 0);
        send_word(ket_pkg::CMD_EVENT, ket_pkg::KEY_BACKSPACE, 0, 0);
        send_word(ket_pkg::CMD_EVENT, ket_pkg::KEY_BACKSPACE, 1, 0); // removes newest
        send_word(ket_pkg::CMD_QUERY, 8'hFF, 1, 0);
        send_word(ket_pkg::CMD_CLR_HIST, 8'h00, 1, 0);
        send_word(ket_pkg::CMD_CLR_ALL, 8'h42, 0, 0);
        send_word(ket_pkg::CMD_QUERY, 8'h42, 0, 0);
        drain();

        // full history: 140 distinct presses with ranges open; key 08h pops as backspace
        for (int i = 0; i < 140; i++) begin
            send_word(ket_pkg::CMD_EVENT, 8'(i), 1, 1);
            send_word(ket_pkg::CMD_EVENT, 8'(i), 0, 1);
        end
        drain();

        // configuration phases, including extremes and inverted range
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(ket_pkg::REG_EVENTS_EN, ph == 3 ? 0 : 1);
            reg_write(ket_pkg::REG_BKSP_EDIT, ph[0]);
            reg_write(ket_pkg::REG_RANGE_CNT, ph % 4);
            reg_write(ket_pkg::REG_RANGE_A,
                      ph == 2 ? 16'h20_40 : (ph == 5 ? 16'hFF_00 : 16'h38_30));
            reg_write(ket_pkg::REG_RANGE_B,
                      ph == 7 ? 16'hFFFF : {8'h3F, 8'($urandom_range(8'h30, 8'h3F))});
            reg_write(ket_pkg::REG_PATTERN, ph == 4 ? 64'hFFFF_FFFF_FFFF_FFFF :
                      {$urandom, $urandom} & 64'h3F3F_3F3F_3F3F_3F3F);
            reg_write(ket_pkg::REG_MATCH_LEN,
                      ph == 6 ? 15 : (ph == 1 ? 0 : $urandom_range(1, 8)));
            random_words(100, 1);
            drain();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
